@@ rtl/fwa_pkg.sv @@
`default_nettype none

package fwa_pkg;

    localparam int ROW_W = 32;
    localparam int SUM_W = 64;
    localparam int CNT_W = 32;
    localparam int SPAN_W = 6;
    localparam int APB_DW = 32;
    localparam int ADDR_W = 4;
    localparam int REG_IDX_W = 2;
    localparam int DIV_STEPS = ROW_W;
    localparam int WINDOW_DEPTH_DEF = 128;

    localparam logic [CNT_W-1:0] ROWS_FULL = '1;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_MODE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRECEDING_ROWS = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FOLLOWING_ROWS = 2'd2;

    typedef struct packed {
        logic              frame_mode;
        logic [SPAN_W-1:0] preceding_rows;
        logic [SPAN_W-1:0] following_rows;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RUN,
        ST_PLAN,
        ST_ADJ,
        ST_ADD,
        ST_SUB,
        ST_DIV,
        ST_OUT
    } fwa_state_t;

endpackage

`default_nettype wire

@@ rtl/fwa_if.sv @@
`default_nettype none

interface fwa_row_if;
    import fwa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ROW_W-1:0] row_value;
    logic                    last_row;

    modport source (output valid, output row_value, output last_row, input ready);
    modport sink (input valid, input row_value, input last_row, output ready);
endinterface

interface fwa_avg_if;
    import fwa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ROW_W-1:0] frame_average;
    logic                    run_end;
    logic                    dataset_end;

    modport source (output valid, output frame_average, output run_end, output dataset_end,
                    input ready);
    modport sink (input valid, input frame_average, input run_end, input dataset_end,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/framed_window_average.sv @@
// Channel    Role            Beat contents
// rows       sink, v/r       row_value (32b signed), last_row
// averages   source, v/r     frame_average (32b signed), run_end, dataset_end
// apb        config, 4b addr frame_mode @0x0, preceding_rows @0x4, following_rows @0x8
//
// Running mode steps through accept, divider start, 32 divider steps, sign fix and
// output load for each row, using the bit-serial divider; the load waits while the output is full.
// Bounded mode moves the frame edges for each result; each row entering or leaving
// the frame takes an adjust and an add or subtract state on the single store read port.
// Reset clears configuration, counters and control; the row store is not cleared.
// A finished result waits in the output register; rows is ready only while idle.
`default_nettype none

module framed_window_average #(
    parameter int WINDOW_DEPTH = fwa_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    fwa_row_if.sink                       rows,
    fwa_avg_if.source                     averages,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fwa_pkg::ADDR_W-1:0]    paddr,
    input  logic [fwa_pkg::APB_DW-1:0]    pwdata,
    output logic [fwa_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import fwa_pkg::*;

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = (AW + 1 > SPAN_W) ? AW + 1 : SPAN_W;
    localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_M1 = CW'(WINDOW_DEPTH - 1);

    cfg_t cfg;

    fwa_state_t state_reg, state_next;

    logic              lat_mode_reg, lat_mode_next;
    logic [SPAN_W-1:0] lat_pre_reg, lat_pre_next;
    logic [SPAN_W-1:0] lat_fol_reg, lat_fol_next;
    logic [CNT_W-1:0]  rows_seen_reg, rows_seen_next;
    logic [CNT_W-1:0]  rows_emitted_reg, rows_emitted_next;
    logic [AW-1:0]     write_slot_reg, write_slot_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  win_lo_reg, win_lo_next;
    logic [CNT_W-1:0]  win_hi_reg, win_hi_next;
    logic [AW-1:0]     lo_slot_reg, lo_slot_next;
    logic [AW-1:0]     hi_slot_reg, hi_slot_next;
    logic [CNT_W-1:0]  tgt_lo_reg, tgt_lo_next;
    logic [CNT_W-1:0]  tgt_hi_reg, tgt_hi_next;
    logic              last_reg, last_next;
    logic              produce_reg, produce_next;
    logic              final_reg, final_next;

    logic              out_valid_reg;
    logic [ROW_W-1:0]  out_avg_reg;
    logic              out_run_end_reg;
    logic              out_ds_end_reg;

    logic              first_row;
    logic              mode_now;
    logic              stored;
    logic [SPAN_W-1:0] fol_clip;
    logic [CW-1:0]     pre_room;
    logic [SPAN_W-1:0] pre_clip;
    logic [CNT_W-1:0]  fol_ext;
    logic [CNT_W-1:0]  pre_ext;
    logic [CNT_W-1:0]  limit;
    logic              more;
    logic [CNT_W-1:0]  lo_cand;
    logic [CNT_W:0]    hi_cand;
    logic [CNT_W-1:0]  hi_tgt;
    logic              is_final;
    logic              need_add;
    logic              need_sub;
    logic              out_free;
    logic              out_load;
    logic              out_ds_end;
    logic              wr_en;
    logic              clear_ds;
    logic              div_start;
    logic              div_done;
    logic [ROW_W-1:0]  div_quot;
    logic [CNT_W-1:0]  divisor;
    logic [AW-1:0]     rd_addr;
    logic [ROW_W-1:0]  rd_data;
    logic [SUM_W-1:0]  in_ext;
    logic [SUM_W-1:0]  rd_ext;

    fwa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fwa_store #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (write_slot_reg),
        .wr_data (rows.row_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fwa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign first_row = (rows_seen_reg == '0);
    assign mode_now = first_row ? cfg.frame_mode : lat_mode_reg;
    assign stored = (rows_seen_reg != ROWS_FULL);

    assign fol_clip = (CW'(cfg.following_rows) > DEPTH_M1) ? SPAN_W'(DEPTH_M1)
                                                             : cfg.following_rows;
    assign pre_room = DEPTH_M1 - CW'(fol_clip);
    assign pre_clip = (CW'(cfg.preceding_rows) > pre_room) ? SPAN_W'(pre_room)
                                                             : cfg.preceding_rows;

    assign fol_ext = CNT_W'(lat_fol_reg);
    assign pre_ext = CNT_W'(lat_pre_reg);
    assign limit = last_reg ? rows_seen_reg
                 : ((rows_seen_reg > fol_ext) ? rows_seen_reg - fol_ext : '0);
    assign more = (rows_emitted_reg < limit);
    assign lo_cand = (rows_emitted_reg > pre_ext) ? rows_emitted_reg - pre_ext : '0;
    assign hi_cand = {1'b0, rows_emitted_reg} + {1'b0, fol_ext} + 1'b1;
    assign hi_tgt = (hi_cand > {1'b0, rows_seen_reg}) ? rows_seen_reg : hi_cand[CNT_W-1:0];
    assign is_final = (({1'b0, rows_emitted_reg} + 1'b1) == {1'b0, limit});

    assign need_add = (win_hi_reg < tgt_hi_reg);
    assign need_sub = (win_lo_reg < tgt_lo_reg);
    assign rd_addr = need_add ? hi_slot_reg : lo_slot_reg;
    assign divisor = lat_mode_reg ? rows_seen_reg : (win_hi_reg - win_lo_reg);

    assign in_ext = {{(SUM_W-ROW_W){rows.row_value[ROW_W-1]}}, rows.row_value};
    assign rd_ext = {{(SUM_W-ROW_W){rd_data[ROW_W-1]}}, rd_data};

    assign out_free = !out_valid_reg || averages.ready;
    assign out_ds_end = lat_mode_reg ? last_reg : (last_reg && final_reg);

    assign rows.ready = (state_reg == ST_IDLE);
    assign averages.valid = out_valid_reg;
    assign averages.frame_average = out_avg_reg;
    assign averages.run_end = out_run_end_reg;
    assign averages.dataset_end = out_ds_end_reg;

    always_comb
    begin
        state_next = state_reg;
        lat_mode_next = lat_mode_reg;
        lat_pre_next = lat_pre_reg;
        lat_fol_next = lat_fol_reg;
        rows_seen_next = rows_seen_reg;
        rows_emitted_next = rows_emitted_reg;
        write_slot_next = write_slot_reg;
        sum_next = sum_reg;
        win_lo_next = win_lo_reg;
        win_hi_next = win_hi_reg;
        lo_slot_next = lo_slot_reg;
        hi_slot_next = hi_slot_reg;
        tgt_lo_next = tgt_lo_reg;
        tgt_hi_next = tgt_hi_reg;
        last_next = last_reg;
        produce_next = produce_reg;
        final_next = final_reg;
        wr_en = 1'b0;
        clear_ds = 1'b0;
        div_start = 1'b0;
        out_load = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (rows.valid)
                begin
                    if (first_row)
                    begin
                        lat_mode_next = cfg.frame_mode;
                        lat_pre_next = pre_clip;
                        lat_fol_next = fol_clip;
                    end
                    if (stored)
                    begin
                        wr_en = 1'b1;
                        write_slot_next = (write_slot_reg == SLOT_LAST) ? '0
                                                                         : write_slot_reg + 1'b1;
                        rows_seen_next = rows_seen_reg + 1'b1;
                        if (mode_now)
                        begin
                            sum_next = sum_reg + in_ext;
                        end
                    end
                    last_next = rows.last_row;
                    produce_next = stored || rows.last_row;
                    state_next = mode_now ? ST_RUN : ST_PLAN;
                end
            end
            ST_RUN:
            begin
                if (produce_reg)
                begin
                    div_start = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PLAN:
            begin
                if (more)
                begin
                    tgt_lo_next = lo_cand;
                    tgt_hi_next = hi_tgt;
                    final_next = is_final;
                    state_next = ST_ADJ;
                end
                else
                begin
                    clear_ds = last_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_ADJ:
            begin
                if (need_add)
                begin
                    state_next = ST_ADD;
                end
                else if (need_sub)
                begin
                    state_next = ST_SUB;
                end
                else
                begin
                    div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_ADD:
            begin
                sum_next = sum_reg + rd_ext;
                win_hi_next = win_hi_reg + 1'b1;
                hi_slot_next = (hi_slot_reg == SLOT_LAST) ? '0 : hi_slot_reg + 1'b1;
                state_next = ST_ADJ;
            end
            ST_SUB:
            begin
                sum_next = sum_reg - rd_ext;
                win_lo_next = win_lo_reg + 1'b1;
                lo_slot_next = (lo_slot_reg == SLOT_LAST) ? '0 : lo_slot_reg + 1'b1;
                state_next = ST_ADJ;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (lat_mode_reg)
                    begin
                        clear_ds = last_reg;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rows_emitted_next = rows_emitted_reg + 1'b1;
                        state_next = ST_PLAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (clear_ds)
        begin
            rows_seen_next = '0;
            rows_emitted_next = '0;
            write_slot_next = '0;
            sum_next = '0;
            win_lo_next = '0;
            win_hi_next = '0;
            lo_slot_next = '0;
            hi_slot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lat_mode_reg <= 1'b0;
            lat_pre_reg <= '0;
            lat_fol_reg <= '0;
            rows_seen_reg <= '0;
            rows_emitted_reg <= '0;
            write_slot_reg <= '0;
            sum_reg <= '0;
            win_lo_reg <= '0;
            win_hi_reg <= '0;
            lo_slot_reg <= '0;
            hi_slot_reg <= '0;
            tgt_lo_reg <= '0;
            tgt_hi_reg <= '0;
            last_reg <= 1'b0;
            produce_reg <= 1'b0;
            final_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lat_mode_reg <= lat_mode_next;
            lat_pre_reg <= lat_pre_next;
            lat_fol_reg <= lat_fol_next;
            rows_seen_reg <= rows_seen_next;
            rows_emitted_reg <= rows_emitted_next;
            write_slot_reg <= write_slot_next;
            sum_reg <= sum_next;
            win_lo_reg <= win_lo_next;
            win_hi_reg <= win_hi_next;
            lo_slot_reg <= lo_slot_next;
            hi_slot_reg <= hi_slot_next;
            tgt_lo_reg <= tgt_lo_next;
            tgt_hi_reg <= tgt_hi_next;
            last_reg <= last_next;
            produce_reg <= produce_next;
            final_reg <= final_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (averages.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_avg_reg <= div_quot;
            out_run_end_reg <= lat_mode_reg ? 1'b1 : final_reg;
            out_ds_end_reg <= out_ds_end;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fwa_cfg.sv @@
`default_nettype none

module fwa_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fwa_pkg::ADDR_W-1:0]    paddr,
    input  logic [fwa_pkg::APB_DW-1:0]    pwdata,
    output logic [fwa_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output fwa_pkg::cfg_t                 cfg
);
    import fwa_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_sel;
    logic                 wr_en;

    assign reg_sel = paddr[ADDR_W-1:2];
    assign wr_en = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_FRAME_MODE:     cfg_next.frame_mode = pwdata[0];
                REG_PRECEDING_ROWS: cfg_next.preceding_rows = pwdata[SPAN_W-1:0];
                REG_FOLLOWING_ROWS: cfg_next.following_rows = pwdata[SPAN_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_FRAME_MODE:     prdata = APB_DW'(cfg_reg.frame_mode);
            REG_PRECEDING_ROWS: prdata = APB_DW'(cfg_reg.preceding_rows);
            REG_FOLLOWING_ROWS: prdata = APB_DW'(cfg_reg.following_rows);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fwa_store.sv @@
`default_nettype none

module fwa_store #(
    parameter int DEPTH = fwa_pkg::WINDOW_DEPTH_DEF,
    parameter int AW = $clog2(fwa_pkg::WINDOW_DEPTH_DEF)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [fwa_pkg::ROW_W-1:0]  wr_data,
    input  logic [AW-1:0]              rd_addr,
    output logic [fwa_pkg::ROW_W-1:0]  rd_data
);
    import fwa_pkg::*;

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/fwa_div.sv @@
`default_nettype none

module fwa_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [fwa_pkg::SUM_W-1:0]  dividend,
    input  logic [fwa_pkg::CNT_W-1:0]         divisor,
    output logic                              done,
    output logic signed [fwa_pkg::ROW_W-1:0]  quotient
);
    import fwa_pkg::*;

    localparam int CW = $clog2(DIV_STEPS);
    localparam logic [CW-1:0] CNT_LAST = CW'(DIV_STEPS - 1);

    logic             busy_reg;
    logic             busy_next;
    logic             fix_reg;
    logic             fix_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic [SUM_W-1:0] rq_reg;
    logic [CNT_W-1:0] den_reg;
    logic             neg_reg;
    logic             zero_reg;
    logic [SUM_W-1:0] mag;
    logic [CNT_W+1:0] trial;
    logic [CNT_W-1:0] hi_new;
    logic [ROW_W-1:0] quot_mag;

    // Restoring division, one quotient bit per cycle. The partial remainder
    // sits in the upper half of the shift register and the quotient bits
    // enter at the bottom.
    assign mag = dividend[SUM_W-1] ? SUM_W'(~dividend + 1'b1) : SUM_W'(dividend);
    assign trial = {1'b0, rq_reg[SUM_W-1:CNT_W], rq_reg[CNT_W-1]} - {2'b00, den_reg};
    assign hi_new = trial[CNT_W+1] ? rq_reg[SUM_W-2:CNT_W-1] : trial[CNT_W-1:0];
    assign quot_mag = rq_reg[ROW_W-1:0];
    assign done = fix_reg;
    assign quotient = zero_reg ? '0 : (neg_reg ? ROW_W'(~quot_mag + 1'b1) : quot_mag);

    always_comb
    begin
        busy_next = busy_reg;
        fix_next = 1'b0;
        cnt_next = cnt_reg;
        if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                fix_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg <= fix_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            rq_reg <= {hi_new, rq_reg[CNT_W-2:0], ~trial[CNT_W+1]};
        end
        else if (start)
        begin
            rq_reg <= mag;
            den_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
            zero_reg <= (divisor == '0);
        end
    end

endmodule

`default_nettype wire

@@ rtl/fwa_checker.sv @@
`default_nettype none

module fwa_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [fwa_pkg::ROW_W-1:0]  out_average,
    input logic                       out_run_end,
    input logic                       out_dataset_end,
    input logic                       pready
);
    import fwa_pkg::*;

    // A beat that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_average)
            && $stable(out_run_end) && $stable(out_dataset_end))
        else $error("result beat changed while stalled");

    // The block works on one row at a time after it takes a beat.
    a_busy_after_row: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("row accepted while previous row still in work");

    // The final result of a dataset always closes the run of its row.
    a_end_marks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !out_dataset_end || out_run_end)
        else $error("dataset end without run end");

    // Register writes never wait.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid || !in_valid |-> pready)
        else $error("configuration port not ready");

endmodule

bind framed_window_average fwa_checker u_fwa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (rows.valid),
    .in_ready        (rows.ready),
    .out_valid       (averages.valid),
    .out_ready       (averages.ready),
    .out_average     (averages.frame_average),
    .out_run_end     (averages.run_end),
    .out_dataset_end (averages.dataset_end),
    .pready          (pready)
);

`default_nettype wire
